FILE: src/dmwc_pkg.sv
// ----------------------------------------------------------------------------
// dmwc_pkg
// Shared types, codes and default sizes for the direct-mapped write-back cache.
// ----------------------------------------------------------------------------
package dmwc_pkg;

	localparam int ADDR_W  = 22;   // byte address width
	localparam int WADDR_W = 20;   // word address width
	localparam int DATA_W  = 32;
	localparam int CNT_W   = 32;

	localparam int NUM_LINES_DEF      = 1024;
	localparam int WORDS_PER_LINE_DEF = 16;
	localparam int MEM_WORDS_DEF      = 1048576;

	typedef enum logic [1:0] {
		ACT_READ    = 2'd0,
		ACT_WRITE   = 2'd1,
		ACT_PRELOAD = 2'd2
	} action_t;

	typedef enum logic [2:0] {
		OUT_HIT     = 3'd0,
		OUT_COLD    = 3'd1,
		OUT_CLEAN   = 3'd2,
		OUT_DIRTY   = 3'd3,
		OUT_PRELOAD = 3'd4
	} outcome_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_TAG_RD,
		ST_TAG_CHK,
		ST_WB,
		ST_FILL,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic [1:0]               action;
		logic [ADDR_W-1:0]        address;
		logic signed [DATA_W-1:0] write_data;
	} item_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] read_data;
		logic [2:0]               outcome;
		logic [CNT_W-1:0]         hit_total;
		logic [CNT_W-1:0]         miss_total;
		logic [CNT_W-1:0]         cold_miss_total;
	} result_t;

	// controller -> datapath
	typedef struct packed {
		logic accept;
		logic tag_rd;
		logic check;
		logic wb;
		logic fill;
		logic finish;
		logic clear;
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic clr_last;
		logic cnt_full;
		logic cache_op;
		logic hit;
		logic vic_valid;
		logic vic_dirty;
	} stat_t;

endpackage

FILE: src/dmwc_ctrl.sv
// ----------------------------------------------------------------------------
// dmwc_ctrl
// Sequencer for clear pass, lookup, writeback, fill and result.
// ----------------------------------------------------------------------------
module dmwc_ctrl import dmwc_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   start,
	input  stat_t  stat,
	output cmd_t   cmd,
	output logic   busy
);

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLEAR: begin
				if (stat.clr_last) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (start) state_d = ST_TAG_RD;
			end
			ST_TAG_RD: begin
				state_d = ST_TAG_CHK;
			end
			ST_TAG_CHK: begin
				priority if (!stat.cache_op || stat.hit) state_d = ST_DONE;
				else if (stat.vic_valid && stat.vic_dirty) state_d = ST_WB;
				else state_d = ST_FILL;
			end
			ST_WB: begin
				if (stat.cnt_full) state_d = ST_FILL;
			end
			ST_FILL: begin
				if (stat.cnt_full) state_d = ST_DONE;
			end
			ST_DONE: begin
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_CLEAR;
			end
		endcase
	end

	always_comb begin
		cmd  = '0;
		busy = (state_q != ST_IDLE);
		unique case (state_q)
			ST_CLEAR:   cmd.clear  = 1'b1;
			ST_IDLE:    cmd.accept = start;
			ST_TAG_RD:  cmd.tag_rd = 1'b1;
			ST_TAG_CHK: cmd.check  = 1'b1;
			ST_WB:      cmd.wb     = 1'b1;
			ST_FILL:    cmd.fill   = 1'b1;
			ST_DONE:    cmd.finish = 1'b1;
			default:    cmd        = '0;
		endcase
	end

endmodule

FILE: src/dmwc_datapath.sv
// ----------------------------------------------------------------------------
// dmwc_datapath
// Line, tag and backing memories, item latch, counters and result register.
// ----------------------------------------------------------------------------
module dmwc_datapath import dmwc_pkg::*; #(
	parameter int NUM_LINES      = NUM_LINES_DEF,
	parameter int WORDS_PER_LINE = WORDS_PER_LINE_DEF,
	parameter int MEM_WORDS      = MEM_WORDS_DEF
) (
	input  logic    clk,
	input  logic    arst_n,
	input  cmd_t    cmd,
	input  item_t   item,
	output stat_t   stat,
	output result_t result,
	output logic    done
);

	localparam int WORD_W  = $clog2(WORDS_PER_LINE);
	localparam int LINE_W  = $clog2(NUM_LINES);
	localparam int TAG_W   = WADDR_W - WORD_W - LINE_W;
	localparam int MEM_W   = $clog2(MEM_WORDS);
	localparam int LWORDS  = NUM_LINES * WORDS_PER_LINE;
	localparam int LADDR_W = LINE_W + WORD_W;
	localparam int TENT_W  = TAG_W + 2;   // {valid, dirty, tag}

	// memories
	logic [DATA_W-1:0] lmem_q [LWORDS];
	logic [TENT_W-1:0] tmem_q [NUM_LINES];
	logic [DATA_W-1:0] bmem_q [MEM_WORDS];

	// payload registers
	item_t             item_q;
	logic [DATA_W-1:0] line_rd_q;
	logic [DATA_W-1:0] mem_rd_q;
	logic [TENT_W-1:0] tag_rd_q;
	logic [DATA_W-1:0] rdata_q;
	outcome_t          outcome_q;
	logic [WORD_W-1:0] wb_idx_s1;
	logic [WORD_W-1:0] fill_idx_s1;
	result_t           result_q;

	// control registers
	logic [WORD_W:0]   cnt_q;
	logic              wb_pend_s1;
	logic              fill_pend_s1;
	logic [MEM_W-1:0]  clr_q;
	logic [CNT_W-1:0]  hit_q;
	logic [CNT_W-1:0]  miss_q;
	logic [CNT_W-1:0]  cold_q;
	logic              done_q;

	// address decode
	logic [WADDR_W-1:0] wa;
	logic [WORD_W-1:0]  word_w;
	logic [LINE_W-1:0]  line_w;
	logic [TAG_W-1:0]   tag_w;
	logic [WORD_W-1:0]  idx;
	logic               cnt_full;
	logic               is_read;
	logic               is_write;
	logic               is_preload;
	logic               cache_op;
	logic               vic_valid;
	logic               vic_dirty;
	logic [TAG_W-1:0]   vic_tag;
	logic               hit;
	logic               dirty_new;

	// port controls
	logic               l_re;
	logic [LADDR_W-1:0] l_raddr;
	logic               l_we;
	logic [LADDR_W-1:0] l_waddr;
	logic [DATA_W-1:0]  l_wdata;
	logic               b_re;
	logic [MEM_W-1:0]   b_raddr;
	logic               b_we;
	logic [MEM_W-1:0]   b_waddr;
	logic [DATA_W-1:0]  b_wdata;
	logic               t_we;
	logic [LINE_W-1:0]  t_waddr;
	logic [TENT_W-1:0]  t_wdata;

	assign wa         = item_q.address[ADDR_W-1:2];
	assign word_w     = wa[WORD_W-1:0];
	assign line_w     = wa[WORD_W +: LINE_W];
	assign tag_w      = wa[WADDR_W-1 -: TAG_W];
	assign idx        = cnt_q[WORD_W-1:0];
	assign cnt_full   = cnt_q[WORD_W];
	assign is_read    = (item_q.action == ACT_READ);
	assign is_write   = (item_q.action == ACT_WRITE);
	assign is_preload = (item_q.action == ACT_PRELOAD);
	assign cache_op   = is_read || is_write;
	assign vic_valid  = tag_rd_q[TENT_W-1];
	assign vic_dirty  = tag_rd_q[TAG_W];
	assign vic_tag    = tag_rd_q[TAG_W-1:0];
	assign hit        = vic_valid && (vic_tag == tag_w);
	// a read hit keeps the line's dirty state; a miss has just refilled it clean
	assign dirty_new  = is_write || (outcome_q == OUT_HIT && vic_dirty);

	assign stat.clr_last  = &clr_q;
	assign stat.cnt_full  = cnt_full;
	assign stat.cache_op  = cache_op;
	assign stat.hit       = hit;
	assign stat.vic_valid = vic_valid;
	assign stat.vic_dirty = vic_dirty;

	// line memory ports
	always_comb begin
		l_re    = cmd.tag_rd || (cmd.wb && !cnt_full);
		l_raddr = cmd.wb ? {line_w, idx} : {line_w, word_w};
		l_we    = fill_pend_s1 || (cmd.finish && is_write);
		l_waddr = fill_pend_s1 ? {line_w, fill_idx_s1} : {line_w, word_w};
		l_wdata = fill_pend_s1 ? mem_rd_q : item_q.write_data;
	end

	// backing memory ports
	always_comb begin
		b_re    = cmd.fill && !cnt_full;
		b_raddr = MEM_W'({tag_w, line_w, idx});
		b_we    = cmd.clear || wb_pend_s1 || (cmd.finish && is_preload);
		priority if (cmd.clear) begin
			b_waddr = clr_q;
			b_wdata = '0;
		end else if (wb_pend_s1) begin
			b_waddr = MEM_W'({vic_tag, line_w, wb_idx_s1});
			b_wdata = line_rd_q;
		end else begin
			b_waddr = MEM_W'(wa);
			b_wdata = item_q.write_data;
		end
	end

	// tag memory write port
	always_comb begin
		t_we    = (cmd.clear && (clr_q[MEM_W-1:LINE_W] == '0)) || (cmd.finish && cache_op);
		t_waddr = cmd.clear ? clr_q[LINE_W-1:0] : line_w;
		t_wdata = cmd.clear ? '0 : {1'b1, dirty_new, tag_w};
	end

	always_ff @(posedge clk) begin
		if (l_we) lmem_q[l_waddr] <= l_wdata;
		if (l_re) line_rd_q <= lmem_q[l_raddr];
	end

	always_ff @(posedge clk) begin
		if (b_we) bmem_q[b_waddr] <= b_wdata;
		if (b_re) mem_rd_q <= bmem_q[b_raddr];
	end

	always_ff @(posedge clk) begin
		if (t_we) tmem_q[t_waddr] <= t_wdata;
		if (cmd.tag_rd) tag_rd_q <= tmem_q[line_w];
	end

	// payload
	always_ff @(posedge clk) begin
		if (cmd.accept) item_q <= item;
		wb_idx_s1   <= idx;
		fill_idx_s1 <= idx;
		if (cmd.check) begin
			rdata_q <= line_rd_q;
			if (!cache_op)     outcome_q <= OUT_PRELOAD;
			else if (hit)      outcome_q <= OUT_HIT;
			else if (!vic_valid) outcome_q <= OUT_COLD;
			else if (vic_dirty)  outcome_q <= OUT_DIRTY;
			else               outcome_q <= OUT_CLEAN;
		end
		if (fill_pend_s1 && (fill_idx_s1 == word_w)) rdata_q <= mem_rd_q;
		if (cmd.finish) begin
			result_q.read_data       <= is_read ? rdata_q : '0;
			result_q.outcome         <= outcome_q;
			result_q.hit_total       <= hit_q;
			result_q.miss_total      <= miss_q;
			result_q.cold_miss_total <= cold_q;
		end
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q        <= '0;
			wb_pend_s1   <= 1'b0;
			fill_pend_s1 <= 1'b0;
			clr_q        <= '0;
			hit_q        <= '0;
			miss_q       <= '0;
			cold_q       <= '0;
			done_q       <= 1'b0;
		end else begin
			if ((cmd.wb || cmd.fill) && !cnt_full) cnt_q <= cnt_q + 1'b1;
			else cnt_q <= '0;
			wb_pend_s1   <= cmd.wb && !cnt_full;
			fill_pend_s1 <= cmd.fill && !cnt_full;
			if (cmd.clear) clr_q <= clr_q + 1'b1;
			if (cmd.check && cache_op) begin
				if (hit) begin
					hit_q <= hit_q + 1'b1;
				end else begin
					miss_q <= miss_q + 1'b1;
					if (!vic_valid) cold_q <= cold_q + 1'b1;
				end
			end
			done_q <= cmd.finish;
		end
	end

	assign result = result_q;
	assign done   = done_q;

endmodule

FILE: src/direct_mapped_writeback_cache.sv
// ----------------------------------------------------------------------------
// direct_mapped_writeback_cache
// Direct-mapped write-back, write-allocate cache with its backing memory.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: drive item (action, byte address, write_data) and raise
//   start; the item is taken at a rising edge where start is high and busy
//   is low. Action read returns a word, write stores one (allocating the
//   line), preload stores straight into the backing memory.
//   Result channel: done pulses for exactly one cycle with result (read
//   word, outcome code, hit/miss/cold-miss totals). The receiver cannot
//   stall; sample result whenever done is high.
//   Sequence from the accept: tag read, tag check, then the result for a
//   hit, preload or unused action; a clean or cold miss fills the line
//   first, and a dirty miss writes the victim back before the fill.
//   Each line walk moves one word a cycle, which sets the miss cost. busy
//   drops in the cycle done is shown, so the next item may be taken while
//   the result is out.
//   Reset: counters clear; the controller then sweeps backing memory
//   (MEM_WORDS words, 1048576 by default) and tag memory, which holds the
//   line valid/dirty state, to zero, one word a cycle, with busy held high.
// ----------------------------------------------------------------------------
module direct_mapped_writeback_cache import dmwc_pkg::*; #(
	parameter int NUM_LINES      = NUM_LINES_DEF,
	parameter int WORDS_PER_LINE = WORDS_PER_LINE_DEF,
	parameter int MEM_WORDS      = MEM_WORDS_DEF
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    start,
	input  item_t   item,
	output logic    busy,
	output logic    done,
	output result_t result
);

	cmd_t  cmd;
	stat_t stat;

	// sequencer: clear pass, lookup, victim writeback, fill, result
	dmwc_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (busy)
	);

	// memories, item latch, event counters and the result register
	dmwc_datapath #(
		.NUM_LINES      (NUM_LINES),
		.WORDS_PER_LINE (WORDS_PER_LINE),
		.MEM_WORDS      (MEM_WORDS)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.item   (item),
		.stat   (stat),
		.result (result),
		.done   (done)
	);

	// an accepted item keeps the block busy until its result is out
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("accepted item did not raise busy");

	// results are single-cycle strobes
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe held longer than one cycle");

	// the block is free again when a result is shown
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result shown while still busy");

	// only a read returns data: preload and unused actions give zero
	a_preload_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.outcome == OUT_PRELOAD) |-> (result.read_data == '0))
		else $error("non-cache item returned data");

endmodule

FILE: test/cache_result_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cache_result_checker
// Watches the item and result channels of the write-back cache, keeps its own
// copy of the cache and backing memory, and checks every result in order.
// ----------------------------------------------------------------------------
module cache_result_checker import dmwc_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    start,
	input  logic    busy,
	input  item_t   item,
	input  logic    done,
	input  result_t result,
	output int      errors,
	output int      pending,
	output int      hits_seen,
	output int      cold_seen,
	output int      clean_seen,
	output int      writebacks_seen,
	output int      bypass_seen
);

	localparam int unsigned LINES = NUM_LINES_DEF;
	localparam int unsigned WPL   = WORDS_PER_LINE_DEF;
	localparam int unsigned MEM   = MEM_WORDS_DEF;

	logic [DATA_W-1:0] line_data [LINES*WPL];
	int unsigned       line_tag  [LINES];
	logic              line_valid[LINES];
	logic              line_dirty[LINES];
	logic [DATA_W-1:0] backing_words [int unsigned];   // absent entry reads as zero
	logic [CNT_W-1:0]  hit_cnt, miss_cnt, cold_cnt;

	result_t predicted_results[$];

	// Bring the addressed line in, writing back a dirty victim first.
	function automatic outcome_t bring_line(input int unsigned line, input int unsigned tag,
			input int unsigned base);
		int unsigned victim;
		int unsigned idx;
		outcome_t    code;
		if (line_valid[line] && line_tag[line] == tag) begin
			hit_cnt = hit_cnt + 1;
			return OUT_HIT;
		end
		if (!line_valid[line]) begin
			code = OUT_COLD;
			cold_cnt = cold_cnt + 1;
		end else if (line_dirty[line]) begin
			victim = (line_tag[line] * LINES + line) * WPL;
			for (int i = 0; i < WPL; i++)
				backing_words[(victim + i) % MEM] = line_data[line*WPL + i];
			code = OUT_DIRTY;
		end else begin
			code = OUT_CLEAN;
		end
		for (int i = 0; i < WPL; i++) begin
			idx = (base + i) % MEM;
			line_data[line*WPL + i] = backing_words.exists(idx) ? backing_words[idx] : '0;
		end
		line_tag[line]   = tag;
		line_valid[line] = 1'b1;
		line_dirty[line] = 1'b0;
		miss_cnt = miss_cnt + 1;
		return code;
	endfunction

	function automatic result_t cache_access(input item_t req);
		int unsigned waddr;
		int unsigned word;
		int unsigned line;
		int unsigned tag;
		result_t     r;
		waddr = 32'(req.address[ADDR_W-1:2]);
		word  = waddr % WPL;
		line  = (waddr / WPL) % LINES;
		tag   = waddr / (WPL * LINES);
		r = '0;
		r.outcome = OUT_PRELOAD;
		case (req.action)
			ACT_READ: begin
				r.outcome   = bring_line(line, tag, waddr - word);
				r.read_data = line_data[line*WPL + word];
			end
			ACT_WRITE: begin
				r.outcome = bring_line(line, tag, waddr - word);
				line_data[line*WPL + word] = req.write_data;
				line_dirty[line] = 1'b1;
			end
			ACT_PRELOAD: begin
				backing_words[waddr % MEM] = req.write_data;
			end
			default: ;   // unused action: no state change
		endcase
		r.hit_total       = hit_cnt;
		r.miss_total      = miss_cnt;
		r.cold_miss_total = cold_cnt;
		return r;
	endfunction

	task automatic compare_result(input result_t want, input result_t got);
		if (got.read_data !== want.read_data) begin
			$error("read_data: expected %h, got %h", want.read_data, got.read_data);
			errors = errors + 1;
		end
		if (got.outcome !== want.outcome) begin
			$error("outcome: expected %0d, got %0d", want.outcome, got.outcome);
			errors = errors + 1;
		end
		if (got.hit_total !== want.hit_total) begin
			$error("hit_total: expected %0d, got %0d", want.hit_total, got.hit_total);
			errors = errors + 1;
		end
		if (got.miss_total !== want.miss_total) begin
			$error("miss_total: expected %0d, got %0d", want.miss_total, got.miss_total);
			errors = errors + 1;
		end
		if (got.cold_miss_total !== want.cold_miss_total) begin
			$error("cold_miss_total: expected %0d, got %0d",
				want.cold_miss_total, got.cold_miss_total);
			errors = errors + 1;
		end
	endtask

	initial begin
		errors = 0;
		pending = 0;
		hits_seen = 0;
		cold_seen = 0;
		clean_seen = 0;
		writebacks_seen = 0;
		bypass_seen = 0;
	end

	always @(posedge clk or negedge arst_n) begin
		result_t want;
		if (!arst_n) begin
			for (int i = 0; i < LINES; i++) begin
				line_valid[i] = 1'b0;
				line_dirty[i] = 1'b0;
			end
			backing_words.delete();
			hit_cnt  = '0;
			miss_cnt = '0;
			cold_cnt = '0;
			predicted_results.delete();
			pending <= 0;
		end else begin
			if (done) begin
				if (predicted_results.size() == 0) begin
					$error("result with no item outstanding");
					errors = errors + 1;
				end else begin
					compare_result(predicted_results.pop_front(), result);
				end
			end
			if (start && !busy) begin
				want = cache_access(item);
				predicted_results.push_back(want);
				case (want.outcome)
					OUT_HIT:   hits_seen = hits_seen + 1;
					OUT_COLD:  cold_seen = cold_seen + 1;
					OUT_CLEAN: clean_seen = clean_seen + 1;
					OUT_DIRTY: writebacks_seen = writebacks_seen + 1;
					default:   bypass_seen = bypass_seen + 1;
				endcase
			end
			pending <= predicted_results.size();
		end
	end

endmodule

FILE: test/direct_mapped_writeback_cache_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// direct_mapped_writeback_cache_test
// Drives reads, writes, preloads and unused actions into the cache: a directed
// run over the corner cases, then random items focused on a few lines and tags
// so that hits, conflicts and writebacks are frequent. A checker beside the
// block predicts and compares every result.
// ----------------------------------------------------------------------------
module direct_mapped_writeback_cache_test;
	import dmwc_pkg::*;

	localparam logic [1:0] ACT_UNUSED = 2'd3;
	localparam int PHASES          = 5;
	localparam int ITEMS_PER_PHASE = 110;
	// Reset sweeps the whole backing memory with busy high; allow for it.
	localparam int STALL_LIMIT     = 4 * MEM_WORDS_DEF;
	localparam int DRAIN_CYCLES    = 80;

	logic    clk = 1'b0;
	logic    arst_n = 1'b0;
	logic    start = 1'b0;
	item_t   item = '0;
	logic    busy;
	logic    done;
	result_t result;

	int errors, pending;
	int hits_seen, cold_seen, clean_seen, writebacks_seen, bypass_seen;
	int stall_cycles = 0;

	// Address pools that keep the random items on a handful of lines and tags
	logic [5:0] tag_pool [4];
	logic [9:0] line_pool[8];
	int         tag_span, line_span;

	always #5 clk = ~clk;

	direct_mapped_writeback_cache u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.item   (item),
		.busy   (busy),
		.done   (done),
		.result (result)
	);

	cache_result_checker u_checker (
		.clk             (clk),
		.arst_n          (arst_n),
		.start           (start),
		.busy            (busy),
		.item            (item),
		.done            (done),
		.result          (result),
		.errors          (errors),
		.pending         (pending),
		.hits_seen       (hits_seen),
		.cold_seen       (cold_seen),
		.clean_seen      (clean_seen),
		.writebacks_seen (writebacks_seen),
		.bypass_seen     (bypass_seen)
	);

	// Watchdog: end the run when neither channel moves for too long.
	always @(posedge clk) begin
		if ((start && !busy) || done) begin
			stall_cycles <= 0;
		end else if (stall_cycles >= STALL_LIMIT) begin
			$display("tb: failure");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	function automatic item_t req(input logic [1:0] act, input logic [ADDR_W-1:0] addr,
			input logic [DATA_W-1:0] data);
		item_t r;
		r.action     = act;
		r.address    = addr;
		r.write_data = data;
		return r;
	endfunction

	function automatic item_t random_request();
		int unsigned pick;
		item_t       r;
		pick = $urandom_range(0, 99);
		if (pick < 45)
			r.action = ACT_READ;
		else if (pick < 85)
			r.action = ACT_WRITE;
		else if (pick < 97)
			r.action = ACT_PRELOAD;
		else
			r.action = ACT_UNUSED;
		// Mostly stay on the pooled lines and tags; sometimes go anywhere.
		if ($urandom_range(0, 99) < 85)
			r.address = {tag_pool[$urandom_range(0, tag_span - 1)],
				line_pool[$urandom_range(0, line_span - 1)], 6'($urandom)};
		else
			r.address = ADDR_W'($urandom);
		case ($urandom_range(0, 9))
			0:       r.write_data = 32'h8000_0000;
			1:       r.write_data = 32'h7fff_ffff;
			2:       r.write_data = 32'hffff_ffff;
			3:       r.write_data = 32'h0000_0000;
			default: r.write_data = $urandom;
		endcase
		return r;
	endfunction

	// Present one item and hold it until the block takes it.
	task automatic issue(input item_t it);
		item  <= it;
		start <= 1'b1;
		do @(posedge clk); while (busy !== 1'b0);
	endtask

	task automatic directed_items();
		// cold miss on line 0, then a hit on it
		issue(req(ACT_READ,  22'h000000, 32'h0));
		issue(req(ACT_READ,  22'h000000, 32'h0));
		// write to an invalid line at the top address; byte offset bits ignored
		issue(req(ACT_WRITE, 22'h3fffff, 32'h7fff_ffff));
		issue(req(ACT_WRITE, 22'h3ffffc, 32'h8000_0000));
		// preload a word of another tag on the same line, then evict the dirty line
		issue(req(ACT_PRELOAD, 22'h00ffc0, 32'hffff_ffff));
		issue(req(ACT_READ,  22'h00ffc0, 32'h0));
		// clean conflict miss that reloads the written-back line
		issue(req(ACT_READ,  22'h3ffffc, 32'h0));
		// preload under a cached copy: the cache keeps the stale word
		issue(req(ACT_PRELOAD, 22'h3ffff8, 32'h1234_5678));
		issue(req(ACT_READ,  22'h3ffff8, 32'h0));
		// dirty the line, evict it: the writeback overwrites the preload
		issue(req(ACT_WRITE, 22'h3ffff0, 32'h0000_0000));
		issue(req(ACT_READ,  22'h00ffc0, 32'h0));
		issue(req(ACT_READ,  22'h3ffff8, 32'h0));
		// unused action code
		issue(req(ACT_UNUSED, 22'h3fffff, 32'hffff_ffff));
		// write to an invalid line, then dirty miss and clean miss on it
		issue(req(ACT_WRITE, 22'h000040, 32'h0000_55aa));
		issue(req(ACT_READ,  22'h010040, 32'h0));
		issue(req(ACT_READ,  22'h000044, 32'h0));
		issue(req(ACT_READ,  22'h000040, 32'h0));
		// preload at word address 0x8000, read it back through a clean miss on line 0
		issue(req(ACT_PRELOAD, 22'h020000, 32'h8000_0000));
		issue(req(ACT_READ,  22'h020000, 32'h0));
		issue(req(ACT_UNUSED, 22'h000000, 32'h0));
	endtask

	task automatic refresh_pools(input int tags, input int lines);
		tag_span  = tags;
		line_span = lines;
		foreach (tag_pool[i])
			tag_pool[i] = 6'($urandom);
		foreach (line_pool[i])
			line_pool[i] = 10'($urandom);
	endtask

	initial begin
		bit idle_on;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		directed_items();

		for (int phase = 0; phase < PHASES; phase++) begin
			// Phase 1 thrashes two lines between two tags.
			if (phase == 1)
				refresh_pools(2, 2);
			else
				refresh_pools($urandom_range(2, 4), $urandom_range(3, 8));
			idle_on = (phase != PHASES - 1);
			for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
				issue(random_request());
				// Drop start for a random burst now and then; none in the last phase.
				if (idle_on && $urandom_range(0, 3) == 0) begin
					start <= 1'b0;
					repeat ($urandom_range(1, 10)) @(posedge clk);
				end
			end
			// Once in the middle, hold off until every result is back.
			if (phase == 2) begin
				start <= 1'b0;
				@(posedge clk);
				while (pending != 0) @(posedge clk);
			end
		end

		// Drain: wait for the last results, then watch for strays.
		start <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("run covered %0d items: %0d hits, %0d cold misses, %0d clean misses,",
			hits_seen + cold_seen + clean_seen + writebacks_seen + bypass_seen,
			hits_seen, cold_seen, clean_seen);
		$display("  %0d dirty misses with writeback, %0d preloads or unused actions",
			writebacks_seen, bypass_seen);
		if (errors == 0 && pending == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
